### sv/wwsm_pkg.sv
// wwsm_pkg: shared types, codes and sizing constants of the whole-word matcher
// used by wwsm_cell, wwsm_res_fifo and whole_word_substring_matcher
`default_nettype none
package wwsm_pkg;

	localparam int MAX_PATTERN_DEF   = 256;
	localparam int MAX_MATCHES_DEF   = 100000;
	localparam int POSITION_BITS_DEF = 32;

	localparam int CNT_OUT_W = 17;
	localparam int POS_OUT_W = 32;
	localparam int RES_DEPTH = 4;

	// input op codes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_TEXT = 2'd1;
	localparam logic [1:0] OP_EOT  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_CASE = 2'd0;
	localparam logic [1:0] REG_WW   = 2'd1;
	localparam logic [1:0] REG_LEN  = 2'd2;
	localparam logic [1:0] REG_REF  = 2'd3;

	localparam logic KIND_MATCH = 1'b0;
	localparam logic KIND_SUM   = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic                 kind;
		logic [POS_OUT_W-1:0] match_position;
		logic [CNT_OUT_W-1:0] total_matches;
		logic [CNT_OUT_W-1:0] current_index;
		logic                 any_match;
		logic                 last;
	} res_t;

endpackage
`default_nettype wire

### sv/wwsm_cell.sv
// wwsm_cell: one pattern slot with its raw and folded partial-match flags
// and one tap of the text window; depends on wwsm_pkg
`default_nettype none
module wwsm_cell
	import wwsm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cell_ctl_t   ctl,
	input  wire logic [15:0] code,
	input  wire logic [15:0] fold,
	input  wire logic [32:0] txt_in,
	input  wire logic        mr_prev,
	input  wire logic        mf_prev,
	output logic             mr_q,
	output logic             mf_q,
	output logic             mr_nxt,
	output logic             mf_nxt,
	output logic [32:0]      txt_q
);

	logic [15:0] raw_q;
	logic [15:0] fld_q;

	// a prefix ending here extends the neighbor's prefix by one character
	assign mr_nxt = mr_prev & (code == raw_q);
	assign mf_nxt = mf_prev & (fold == fld_q);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			raw_q <= code;
			fld_q <= fold;
		end
		if (ctl.step)
			txt_q <= txt_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mr_q <= 1'b0;
			mf_q <= 1'b0;
		end else if (ctl.clear) begin
			mr_q <= 1'b0;
			mf_q <= 1'b0;
		end else if (ctl.step) begin
			mr_q <= mr_nxt;
			mf_q <= mf_nxt;
		end
	end

endmodule
`default_nettype wire

### sv/wwsm_res_fifo.sv
// wwsm_res_fifo: small result queue taking up to two beats per cycle
// depends on wwsm_pkg
`default_nettype none
module wwsm_res_fifo
	import wwsm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push0,
	input  wire logic push1,
	input  wire res_t data0,
	input  wire res_t data1,
	output logic      room2,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_data
);

	localparam int PW = $clog2(RES_DEPTH);
	localparam int CW = $clog2(RES_DEPTH + 1);

	res_t          mem [RES_DEPTH];
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] cnt_q;
	logic          pop;
	logic [CW-1:0] n_push;

	assign out_valid = (cnt_q != '0);
	assign out_data  = mem[head_q];
	assign pop       = out_valid & out_ready;
	assign room2     = (32'(cnt_q) + 2 <= RES_DEPTH);
	assign n_push    = CW'({1'b0, push0} + {1'b0, push1});

	always_ff @(posedge clk) begin
		if (push0)
			mem[tail_q] <= data0;
		if (push1)
			mem[PW'(tail_q + PW'(push0))] <= data1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop)
				head_q <= PW'(head_q + 1'b1);
			tail_q <= PW'(tail_q + PW'(n_push));
			cnt_q  <= CW'(cnt_q + n_push - CW'(pop));
		end
	end

endmodule
`default_nettype wire

### sv/whole_word_substring_matcher.sv
// whole_word_substring_matcher: top level, register port, cell chain and match decision
// depends on wwsm_pkg, wwsm_cell, wwsm_res_fifo
//
// channel  | dir | beat fields
// in       | in  | op, pattern_index, char_code, folded_code, is_word_char
// out      | out | kind, match_position, total_matches, current_index, any_match, last
// apb      | in  | case_sensitive, whole_word, pattern_length, reference_position
//
// one input beat per cycle while the result queue has room for two beats and no replay
// runs; results enter the queue at the accepting edge and are offered from the next cycle
// the decision for a candidate start is taken in the accepting cycle
// in_ready drops while the queue holds more than two results
// a pattern load in the middle of a text stalls the next non-load beat while the stored
// window replays through the chain; reset clears state, not slots
`default_nettype none
module whole_word_substring_matcher
	import wwsm_pkg::*;
#(
	parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
	parameter int MAX_MATCHES   = MAX_MATCHES_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  pattern_index,
	input  wire logic [15:0] char_code,
	input  wire logic [15:0] folded_code,
	input  wire logic        is_word_char,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [31:0]      match_position,
	output logic [16:0]      total_matches,
	output logic [16:0]      current_index,
	output logic             any_match,
	output logic             last
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CNT_W = $clog2(MAX_MATCHES + 1);
	localparam int PB    = POSITION_BITS;

	logic              case_q;
	logic              ww_q;
	logic [8:0]        plen_q;
	logic [31:0]       ref_q;
	logic [PB-1:0]     pos_q;
	logic [PB-1:0]     nas_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  below_q;
	logic              seen_q;
	logic              wlast_q;
	logic              dirty_q;
	logic              busy_q;
	logic [IDX_W-1:0]  rcnt_q;

	logic [MAX_PATTERN-1:0] mr_q, mf_q, mr_nxt, mf_nxt;
	logic [32:0]            txt_q [MAX_PATTERN];
	logic [32:0]            txt_in [MAX_PATTERN];
	logic [MAX_PATTERN:0]   word_vec;
	logic [MAX_PATTERN-1:0] mr_in, mf_in;
	logic [15:0]            cmp_raw, cmp_fold;

	logic              in_fire, cfg_wr, rep_start;
	logic              is_text, is_eot;
	logic [LEN_W-1:0]  len;
	logic [IDX_W-1:0]  end_idx;
	logic              cand_en, eq, prev_w, bounds_ok, take, below_hit;
	logic [PB-1:0]     s;
	logic [CNT_W-1:0]  cnt_nx, below_nx;
	logic              seen_nx;
	logic              room2;
	res_t              r_match, r_sum, d0, d1, out_data;
	logic              push0, push1;
	cell_ctl_t         ctl [MAX_PATTERN];

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[3:2])
			REG_CASE: prdata = {31'd0, case_q};
			REG_WW:   prdata = {31'd0, ww_q};
			REG_LEN:  prdata = {23'd0, plen_q};
			REG_REF:  prdata = ref_q;
			default:  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_q <= 1'b0;
			ww_q   <= 1'b0;
			plen_q <= '0;
			ref_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CASE: case_q <= pwdata[0];
				REG_WW:   ww_q   <= pwdata[0];
				REG_LEN:  plen_q <= pwdata[8:0];
				REG_REF:  ref_q  <= pwdata;
				default:  ;
			endcase
		end
	end

	// a pattern reloaded mid-text makes the prefix flags stale until the window replays
	assign rep_start = in_valid && dirty_q && !busy_q && (op != OP_LOAD);
	assign in_ready  = room2 && !busy_q && !(dirty_q && (op != OP_LOAD));
	assign in_fire   = in_valid & in_ready;
	assign is_text   = (op == OP_TEXT) && (pos_q != {PB{1'b1}});
	assign is_eot    = (op == OP_EOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b0;
			busy_q  <= 1'b0;
			rcnt_q  <= '0;
		end else begin
			if (in_fire && (op == OP_LOAD) && (pos_q != '0))
				dirty_q <= 1'b1;
			else if (rep_start)
				dirty_q <= 1'b0;
			if (rep_start) begin
				busy_q <= 1'b1;
				rcnt_q <= '0;
			end else if (busy_q) begin
				rcnt_q <= IDX_W'(rcnt_q + 1'b1);
				if (rcnt_q == IDX_W'(MAX_PATTERN - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// cell chain; during a replay the window rotates once, oldest character first
	assign txt_in[0]   = busy_q ? txt_q[MAX_PATTERN-1] : {is_word_char, folded_code, char_code};
	assign cmp_raw     = busy_q ? txt_q[MAX_PATTERN-1][15:0] : char_code;
	assign cmp_fold    = busy_q ? txt_q[MAX_PATTERN-1][31:16] : folded_code;
	assign word_vec[0] = is_word_char;
	assign mr_in[0]    = 1'b1;
	assign mf_in[0]    = 1'b1;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign mr_in[i]  = mr_q[i-1];
			assign mf_in[i]  = mf_q[i-1];
			assign txt_in[i] = txt_q[i-1];
		end
		assign ctl[i].load  = in_fire && (op == OP_LOAD) && (32'(pattern_index) == i);
		assign ctl[i].step  = (in_fire && is_text) || busy_q;
		assign ctl[i].clear = in_fire && is_eot;
		assign word_vec[i+1] = txt_q[i][32];

		wwsm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[i]),
			.code    (cmp_raw),
			.fold    (cmp_fold),
			.txt_in  (txt_in[i]),
			.mr_prev (mr_in[i]),
			.mf_prev (mf_in[i]),
			.mr_q    (mr_q[i]),
			.mf_q    (mf_q[i]),
			.mr_nxt  (mr_nxt[i]),
			.mf_nxt  (mf_nxt[i]),
			.txt_q   (txt_q[i])
		);
	end

	// word flag one place beyond the longest pattern
	always_ff @(posedge clk) begin
		if (in_fire && is_text)
			wlast_q <= txt_q[MAX_PATTERN-1][32];
	end

	// decision for the candidate start
	always_comb begin
		len = (32'(plen_q) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : LEN_W'(plen_q);
		end_idx = IDX_W'(len - 1'b1);
		// character just before the start of a whole-word candidate
		prev_w  = (32'(len) == MAX_PATTERN) ? wlast_q : word_vec[LEN_W'(len + 1'b1)];
		if (is_text && !ww_q) begin
			s       = PB'(pos_q + 1'b1 - PB'(len));
			cand_en = (len != '0) && ((33'(pos_q) + 1) >= 33'(len));
			eq      = case_q ? mr_nxt[end_idx] : mf_nxt[end_idx];
		end else begin
			s       = PB'(pos_q - PB'(len));
			cand_en = (len != '0) && ww_q && (33'(pos_q) >= 33'(len)) && (is_text || is_eot);
			eq      = case_q ? mr_q[end_idx] : mf_q[end_idx];
		end
		// text end counts as a boundary after the match
		bounds_ok = !ww_q || ((s == '0 || !prev_w) && (is_eot || !is_word_char));
		take = in_fire && cand_en && (32'(cnt_q) < MAX_MATCHES) && (s >= nas_q) && eq
			&& bounds_ok;
		below_hit = (32'(s) < ref_q);
		cnt_nx    = take ? CNT_W'(cnt_q + 1'b1) : cnt_q;
		below_nx  = (take && below_hit) ? CNT_W'(below_q + 1'b1) : below_q;
		seen_nx   = seen_q || (take && !below_hit);
	end

	always_comb begin
		r_match.kind           = KIND_MATCH;
		r_match.match_position = POS_OUT_W'(s);
		r_match.total_matches  = CNT_OUT_W'(cnt_q + 1'b1);
		r_match.current_index  = '0;
		r_match.any_match      = 1'b1;
		r_match.last           = is_text;
		// the summary includes a match taken at text end
		r_sum.kind             = KIND_SUM;
		r_sum.match_position   = '0;
		r_sum.total_matches    = CNT_OUT_W'(cnt_nx);
		r_sum.current_index    = seen_nx ? CNT_OUT_W'(below_nx) : '0;
		r_sum.any_match        = (cnt_nx != '0);
		r_sum.last             = 1'b1;
		// with no match the summary takes the first slot
		push0 = take || (in_fire && is_eot);
		push1 = take && is_eot;
		d0    = take ? r_match : r_sum;
		d1    = r_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			nas_q   <= '0;
			cnt_q   <= '0;
			below_q <= '0;
			seen_q  <= 1'b0;
		end else if (in_fire && is_eot) begin
			pos_q   <= '0;
			nas_q   <= '0;
			cnt_q   <= '0;
			below_q <= '0;
			seen_q  <= 1'b0;
		end else begin
			if (in_fire && is_text)
				pos_q <= PB'(pos_q + 1'b1);
			if (take) begin
				cnt_q   <= cnt_nx;
				nas_q   <= PB'(s + PB'(len));
				below_q <= below_nx;
				seen_q  <= seen_nx;
			end
		end
	end

	wwsm_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.push1     (push1),
		.data0     (d0),
		.data1     (d1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign kind           = out_data.kind;
	assign match_position = out_data.match_position;
	assign total_matches  = out_data.total_matches;
	assign current_index  = out_data.current_index;
	assign any_match      = out_data.any_match;
	assign last           = out_data.last;

endmodule
`default_nettype wire
